[hw/rtl/rhv_pkg.sv]
package rhv_pkg;

    localparam int NUM_BINS    = 100;
    localparam int RAW_OFFSET  = 55;
    localparam int DBM_AT_BIN0 = -100;
    localparam int CNT_W       = 24;
    localparam int ADDR_W      = $clog2(NUM_BINS);
    localparam int CFG_IDX_W   = 1;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LENGTH = 1'b1;

    typedef struct packed {
        logic [1:0]        action;
        logic signed [7:0] rssi_raw;
        logic [6:0]        bin_index;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] bin_count;
        logic             bin_nonzero;
        logic [CNT_W-1:0] vacancy_count;
        logic [CNT_W-1:0] samples_taken;
        logic             scan_done;
        logic [CNT_W-1:0] dropped_count;
    } rsp_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  data;
    } bin_wr_t;

    function automatic logic signed [9:0] bin_of(input logic signed [7:0] raw);
        return 10'(raw) + 10'(RAW_OFFSET);
    endfunction

    function automatic logic bin_in_range(input logic signed [9:0] b);
        return (b >= 0) && (b < NUM_BINS);
    endfunction

    function automatic logic [ADDR_W-1:0] cmd_addr(input cmd_t c);
        logic signed [9:0] b;
        b = bin_of(c.rssi_raw);
        return (c.action == ACT_READ) ? ADDR_W'(c.bin_index) : ADDR_W'(b);
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

endpackage

[hw/rtl/rhv_bin_ram.sv]
module rhv_bin_ram #(
    parameter int DEPTH = 100,
    parameter int WIDTH = 24,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

[hw/rtl/rhv_count_unit.sv]
module rhv_count_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  rhv_pkg::cmd_t                cmd,
    input  logic [rhv_pkg::CNT_W-1:0]    rdata,
    output rhv_pkg::bin_wr_t             wr,
    output rhv_pkg::rsp_t                rsp,
    input  logic                         cfg_we,
    input  logic [rhv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rhv_pkg::CNT_W-1:0]    cfg_data
);
    import rhv_pkg::*;

    logic [NUM_BINS-1:0] bin_valid_reg, bin_valid_next;
    logic                fwd_valid_reg;
    logic [ADDR_W-1:0]   fwd_addr_reg;
    logic [CNT_W-1:0]    fwd_data_reg;
    logic [CNT_W-1:0]    vacant_reg, vacant_next;
    logic [CNT_W-1:0]    accepted_reg, accepted_next;
    logic [CNT_W-1:0]    dropped_reg, dropped_next;
    logic signed [7:0]   threshold_reg;
    logic [CNT_W-1:0]    scan_length_reg;

    logic signed [9:0]   bin;
    logic signed [9:0]   dbm;
    logic                bin_ok;
    logic                idx_ok;
    logic [ADDR_W-1:0]   addr;
    logic                hit_ok;
    logic [CNT_W-1:0]    stored;
    logic                full;
    logic                take;
    logic                do_clear;

    assign bin    = bin_of(cmd.rssi_raw);
    assign dbm    = bin + 10'(DBM_AT_BIN0);
    assign bin_ok = bin_in_range(bin);
    assign idx_ok = 32'(cmd.bin_index) < NUM_BINS;
    assign addr   = cmd_addr(cmd);
    assign hit_ok = (cmd.action == ACT_READ) ? idx_ok : bin_ok;

    always_comb
    begin
        stored = '0;
        if (hit_ok && bin_valid_reg[addr])
        begin
            stored = (fwd_valid_reg && fwd_addr_reg == addr) ? fwd_data_reg : rdata;
        end
    end

    assign full     = accepted_reg >= scan_length_reg;
    assign take     = fire && cmd.action == ACT_SAMPLE && !full;
    assign do_clear = fire && cmd.action == ACT_CLEAR;

    assign wr.we   = take && bin_ok;
    assign wr.addr = addr;
    assign wr.data = sat_inc(stored);

    always_comb
    begin
        bin_valid_next = bin_valid_reg;
        vacant_next    = vacant_reg;
        accepted_next  = accepted_reg;
        dropped_next   = dropped_reg;
        if (do_clear)
        begin
            bin_valid_next = '0;
            vacant_next    = '0;
            accepted_next  = '0;
            dropped_next   = '0;
        end
        else if (take)
        begin
            accepted_next = sat_inc(accepted_reg);
            if (!bin_ok)
            begin
                dropped_next = sat_inc(dropped_reg);
            end
            else
            begin
                bin_valid_next[addr] = 1'b1;
                if (dbm < 10'(threshold_reg))
                begin
                    vacant_next = sat_inc(vacant_reg);
                end
            end
        end
    end

    assign rsp.bin_count     = stored;
    assign rsp.bin_nonzero   = stored != '0;
    assign rsp.vacancy_count = vacant_reg;
    assign rsp.samples_taken = accepted_reg;
    assign rsp.scan_done     = full;
    assign rsp.dropped_count = dropped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_valid_reg   <= '0;
            fwd_valid_reg   <= 1'b0;
            vacant_reg      <= '0;
            accepted_reg    <= '0;
            dropped_reg     <= '0;
            threshold_reg   <= -8'sd77;
            scan_length_reg <= CNT_W'(2000000);
        end
        else
        begin
            bin_valid_reg <= bin_valid_next;
            vacant_reg    <= vacant_next;
            accepted_reg  <= accepted_next;
            dropped_reg   <= dropped_next;
            if (do_clear)
            begin
                fwd_valid_reg <= 1'b0;
            end
            else if (wr.we)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_THRESHOLD:   threshold_reg   <= cfg_data[7:0];
                    CFG_SCAN_LENGTH: scan_length_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            fwd_addr_reg <= wr.addr;
            fwd_data_reg <= wr.data;
        end
    end

endmodule

[hw/rtl/rssi_histogram_vacancy_core.sv]
// channel | dir | handshake           | payload
// cmd     | in  | cmd_valid/cmd_stall | cmd   (action, rssi_raw, bin_index)
// rsp     | out | rsp_valid/rsp_stall | rsp   (bin and scan counters, read only)
// cfg     | in  | cfg_we              | cfg_index, cfg_data
//
// One command per cycle sustained while cmd_stall is low; a read is held in s1, then its result in rsp_reg.
// Bin RAM read is issued at transfer, update and write-back follow from the s1 register;
// a one-entry write forward covers back-to-back hits on the same bin.
// Clear drops the per-bin valid flops, no RAM sweep.
// Reset clears the counters and valid flops, loads threshold -77 dBm and length 2000000.
// cmd_stall rises only while a read result waits on a stalled rsp.
module rssi_histogram_vacancy_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  rhv_pkg::cmd_t                 cmd,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output rhv_pkg::rsp_t                 rsp,
    input  logic                          cfg_we,
    input  logic [rhv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rhv_pkg::CNT_W-1:0]     cfg_data
);
    import rhv_pkg::*;

    logic             s1_valid_reg;
    cmd_t             s1_cmd_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;
    logic             blocked;
    logic             accept;
    logic             fire;
    logic [CNT_W-1:0] rdata;
    bin_wr_t          wr;
    rsp_t             result;

    assign blocked   = s1_valid_reg && s1_cmd_reg.action == ACT_READ
                       && rsp_valid_reg && rsp_stall;
    assign cmd_stall = blocked;
    assign accept    = cmd_valid && !blocked;
    assign fire      = s1_valid_reg && !blocked;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    rhv_bin_ram #(
        .DEPTH (NUM_BINS),
        .WIDTH (CNT_W)
    ) u_ram (
        .clk   (clk),
        .re    (accept),
        .raddr (cmd_addr(cmd)),
        .rdata (rdata),
        .we    (wr.we),
        .waddr (wr.addr),
        .wdata (wr.data)
    );

    rhv_count_unit u_count (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .cmd       (s1_cmd_reg),
        .rdata     (rdata),
        .wr        (wr),
        .rsp       (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (!blocked)
            begin
                s1_valid_reg <= cmd_valid;
            end
            if (fire && s1_cmd_reg.action == ACT_READ)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= cmd;
        end
        if (fire && s1_cmd_reg.action == ACT_READ)
        begin
            rsp_reg <= result;
        end
    end

endmodule

[hw/rtl/rhv_checker.sv]
module rhv_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_stall,
    input rhv_pkg::cmd_t                 cmd,
    input logic                          rsp_valid,
    input logic                          rsp_stall,
    input rhv_pkg::rsp_t                 rsp
);
    import rhv_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("rsp changed while stalled");

    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.bin_nonzero == (rsp.bin_count != '0))
        else $error("bin_nonzero disagrees with bin_count");

    a_rsp_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd_valid && !cmd_stall && cmd.action == ACT_READ, 2))
        else $error("result without a read transfer");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> rsp_valid && rsp_stall)
        else $error("cmd stalled with rsp free");

endmodule

bind rssi_histogram_vacancy_core rhv_checker u_rhv_checker (.*);

[tb/rhv_histogram_checker.sv]
module rhv_histogram_checker
    import rhv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  logic                 cmd_stall,
    input  cmd_t                 cmd,
    input  logic                 rsp_valid,
    input  logic                 rsp_stall,
    input  rsp_t                 rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data,
    output int unsigned          errors,
    output int unsigned          outstanding,
    output int unsigned          results_seen
);

    logic [CNT_W-1:0]  bin_tally [NUM_BINS];
    logic [CNT_W-1:0]  vacant_cnt;
    logic [CNT_W-1:0]  taken_cnt;
    logic [CNT_W-1:0]  dropped_cnt;
    logic signed [7:0] thr_dbm;
    logic [CNT_W-1:0]  scan_len;
    rsp_t              expected_reads [$];
    int unsigned       mismatches = 0;
    int unsigned       compared = 0;

    assign errors       = mismatches;
    assign results_seen = compared;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    task automatic wipe_histogram();
        for (int i = 0; i < NUM_BINS; i++)
        begin
            bin_tally[i] = '0;
        end
        vacant_cnt  = '0;
        taken_cnt   = '0;
        dropped_cnt = '0;
    endtask

    task automatic tally_cmd(input cmd_t c);
        int   slot;
        rsp_t r;
        if (c.action == ACT_SAMPLE)
        begin
            if (taken_cnt < scan_len)
            begin
                taken_cnt = bump(taken_cnt);
                slot = int'($signed(c.rssi_raw)) + RAW_OFFSET;
                if (slot < 0 || slot >= NUM_BINS)
                begin
                    dropped_cnt = bump(dropped_cnt);
                end
                else
                begin
                    bin_tally[slot] = bump(bin_tally[slot]);
                    if (slot + DBM_AT_BIN0 < int'(thr_dbm))
                    begin
                        vacant_cnt = bump(vacant_cnt);
                    end
                end
            end
        end
        else if (c.action == ACT_READ)
        begin
            r.bin_count     = (int'(c.bin_index) < NUM_BINS) ? bin_tally[c.bin_index] : '0;
            r.bin_nonzero   = (r.bin_count != '0);
            r.vacancy_count = vacant_cnt;
            r.samples_taken = taken_cnt;
            r.scan_done     = (taken_cnt >= scan_len);
            r.dropped_count = dropped_cnt;
            expected_reads.push_back(r);
        end
        else if (c.action == ACT_CLEAR)
        begin
            wipe_histogram();
        end
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: read result %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            wipe_histogram();
            thr_dbm  = -8'sd77;
            scan_len = 24'd2000000;
            expected_reads.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_THRESHOLD)
                begin
                    thr_dbm = cfg_data[7:0];
                end
                else if (cfg_index == CFG_SCAN_LENGTH)
                begin
                    scan_len = cfg_data;
                end
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_reads.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: read result with no read pending, got %p", $time, rsp);
                end
                else
                begin
                    want = expected_reads.pop_front();
                    compared++;
                    check_field("bin_count", want.bin_count, rsp.bin_count);
                    check_field("bin_nonzero", CNT_W'(want.bin_nonzero),
                                CNT_W'(rsp.bin_nonzero));
                    check_field("vacancy_count", want.vacancy_count, rsp.vacancy_count);
                    check_field("samples_taken", want.samples_taken, rsp.samples_taken);
                    check_field("scan_done", CNT_W'(want.scan_done), CNT_W'(rsp.scan_done));
                    check_field("dropped_count", want.dropped_count, rsp.dropped_count);
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                tally_cmd(cmd);
            end
            outstanding <= expected_reads.size();
        end
    end

endmodule

[tb/tb_rssi_histogram_vacancy_core.sv]
module tb_rssi_histogram_vacancy_core;

    import rhv_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 225;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cmd_valid = 1'b0;
    logic                 cmd_stall;
    cmd_t                 cmd = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_t                 rsp;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0]     cfg_data = '0;

    int unsigned errors;
    int unsigned outstanding;
    int unsigned results_seen;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned n_samples = 0;
    int unsigned n_reads = 0;
    int unsigned n_clears = 0;
    int unsigned n_unused = 0;
    int unsigned n_settings = 0;

    int         phase_thr [NUM_PHASES] = '{-1, -100, 127, -128, -60, -77, -20, 0};
    int         phase_len [NUM_PHASES] = '{16777215, 40, 16777215, 1, 150, 2000000, 90, 0};
    idle_mode_t phase_idle [NUM_PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                            IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};

    rssi_histogram_vacancy_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rhv_histogram_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp          (rsp),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("tb_rssi_histogram_vacancy_core failed");
        $finish;
    end

    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic set_idle(input idle_mode_t mode);
        send_idle_pct  = (mode == IDLE_SEND) ? 73 : (mode == IDLE_BOTH) ? 23 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 73 : (mode == IDLE_BOTH) ? 23 : 0;
    endtask

    task automatic push_cmd(input cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
        case (c.action)
            ACT_SAMPLE: n_samples++;
            ACT_READ:   n_reads++;
            ACT_CLEAR:  n_clears++;
            default:    n_unused++;
        endcase
    endtask

    task automatic send_cmd(input logic [1:0] act, input int raw, input int idx);
        cmd_t c;
        c.action    = act;
        c.rssi_raw  = 8'(raw);
        c.bin_index = 7'(idx);
        push_cmd(c);
    endtask

    task automatic send_sample(input int raw);
        send_cmd(ACT_SAMPLE, raw, $urandom_range(127));
    endtask

    task automatic read_bin(input int idx);
        send_cmd(ACT_READ, $urandom_range(255), idx);
    endtask

    task automatic send_clear();
        send_cmd(ACT_CLEAR, $urandom_range(255), $urandom_range(127));
    endtask

    // hold until every read result is back or max_cycles pass, and in-flight updates have settled
    task automatic drain(input int unsigned max_cycles);
        int unsigned waited;
        waited = 0;
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 && waited < max_cycles)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic configure(input int thr, input int len);
        write_reg(CFG_THRESHOLD, 24'(thr));
        write_reg(CFG_SCAN_LENGTH, 24'(len));
        n_settings++;
    endtask

    task automatic random_item();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            if ($urandom_range(99) < 80)
                send_sample(int'($urandom_range(99)) - 55);
            else
                send_sample(int'($urandom_range(255)) - 128);
        end
        else if (pick < 92)
        begin
            if ($urandom_range(99) < 85)
                read_bin($urandom_range(99));
            else
                read_bin($urandom_range(127, 100));
        end
        else if (pick < 96)
        begin
            send_clear();
        end
        else
        begin
            send_cmd(ACT_UNUSED, $urandom_range(255), $urandom_range(127));
        end
    endtask

    initial
    begin
        int thr;
        int len;
        set_idle(IDLE_NONE);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: drops at both ends, first and last bin, threshold edge
        send_sample(-128);
        send_sample(127);
        send_sample(-56);
        send_sample(45);
        send_sample(-55);
        send_sample(44);
        send_sample(-33);
        send_sample(-32);
        send_sample(-32);
        read_bin(0);
        read_bin(99);
        read_bin(23);
        read_bin(100);
        read_bin(127);
        send_cmd(ACT_UNUSED, 0, 23);
        send_clear();
        read_bin(23);
        drain(200);

        // scan end and zero scan length
        configure(-1, 3);
        repeat (4) send_sample(0);
        read_bin(55);
        send_clear();
        drain(200);
        configure(-1, 0);
        send_sample(0);
        read_bin(55);
        drain(200);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            thr = phase_thr[p];
            len = phase_len[p];
            if (p == NUM_PHASES - 1)
            begin
                thr = int'($urandom_range(99)) - 100;
                len = $urandom_range(300, 20);
            end
            configure(thr, len);
            send_clear();
            set_idle(phase_idle[p]);
            repeat (PHASE_ITEMS) random_item();
            set_idle(IDLE_NONE);
            drain(5000);
        end

        if (outstanding != 0)
            $display("%0d read results never arrived", outstanding);
        $display("covered %0d samples, %0d reads, %0d clears, %0d unused codes",
                 n_samples, n_reads, n_clears, n_unused);
        $display("%0d read results compared across %0d register settings",
                 results_seen, n_settings);
        if (errors == 0 && outstanding == 0)
            $display("tb_rssi_histogram_vacancy_core passed");
        else
            $display("tb_rssi_histogram_vacancy_core failed");
        $finish;
    end

endmodule
